[rtl/rigid_body_euler_step_with_sleep_top_macros.svh]
// assertion macros for the rigid body euler step block
// used by the checker module bound to the top level
`ifndef RIGID_BODY_EULER_STEP_WITH_SLEEP_TOP_MACROS_SVH
`define RIGID_BODY_EULER_STEP_WITH_SLEEP_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RBES_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbes same cycle check failed");

// antecedent implies consequent in the next cycle
`define RBES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbes next cycle check failed");

`endif

[rtl/rbes_pkg.sv]
// shared types and constants for the rigid body euler step block
// no dependencies; used by every rtl file except the assertion macro header
`timescale 1ns / 1ps

package rbes_pkg;

   typedef enum logic [1:0] {
      OP_STEP     = 2'd0,
      OP_LOAD_LIN = 2'd1,
      OP_LOAD_ANG = 2'd2
   } op_type;

   localparam logic [2:0] CSR_INV_MASS    = 3'd0;
   localparam logic [2:0] CSR_INV_INERTIA = 3'd1;
   localparam logic [2:0] CSR_GRAVITY     = 3'd2;
   localparam logic [2:0] CSR_MODE        = 3'd3;
   localparam logic [2:0] CSR_SPEED_LIMIT = 3'd4;
   localparam logic [2:0] CSR_TIME_LIMIT  = 3'd5;

   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [15:0] INV_MASS_RESET    = 16'h0100;
   localparam logic [47:0] INV_INERTIA_RESET = 48'h0100_0100_0100;
   localparam logic [47:0] GRAVITY_RESET     = 48'h0;
   localparam logic [2:0]  MODE_RESET        = 3'b111;
   localparam logic [15:0] SPEED_LIMIT_RESET = 16'h0;
   localparam logic [23:0] TIME_LIMIT_RESET  = 24'h0;

   localparam int unsigned MODE_DYNAMIC = 0;
   localparam int unsigned MODE_GRAVITY = 1;
   localparam int unsigned MODE_SLEEP   = 2;

   localparam logic [23:0]        TIMER_MAX  = 24'hFF_FFFF;
   localparam logic signed [49:0] ROUND_HALF = 50'sd8388608;

   localparam logic [1:0] AXIS_FIRST = 2'd0;
   localparam logic [1:0] AXIS_LAST  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ACCEL,
      ST_APPLY,
      ST_SQUARE,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
      logic signed [15:0] torque_x;
      logic signed [15:0] torque_y;
      logic signed [15:0] torque_z;
      logic [15:0]        time_step;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] lin_vel_x;
      logic signed [15:0] lin_vel_y;
      logic signed [15:0] lin_vel_z;
      logic signed [15:0] ang_vel_x;
      logic signed [15:0] ang_vel_y;
      logic signed [15:0] ang_vel_z;
      logic               asleep;
   } rsp_payload_type;

   typedef struct packed {
      logic       capture;
      logic       start;
      logic       accel;
      logic       apply;
      logic       square;
      logic       decide;
      logic       finish;
      logic [1:0] axis;
   } dp_cmd_type;

   typedef struct packed {
      logic is_step;
      logic integrate;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/rbes_ctrl.sv]
// controller state machine for the rigid body euler step block
// depends on rbes_pkg; drives commands to rbes_datapath
`timescale 1ns / 1ps

module rbes_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rbes_pkg::dp_status_type status,
   output rbes_pkg::dp_cmd_type    cmd
);

   rbes_pkg::state_type state_ff, state_in;
   logic [1:0]          axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbes_pkg::ST_IDLE;
         axis_ff  <= rbes_pkg::AXIS_FIRST;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         rbes_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rbes_pkg::ST_START;
            end
         end
         rbes_pkg::ST_START: begin
            axis_in = rbes_pkg::AXIS_FIRST;
            if (!status.is_step) begin
               state_in = rbes_pkg::ST_DONE;
            end else if (status.integrate) begin
               state_in = rbes_pkg::ST_ACCEL;
            end else begin
               state_in = rbes_pkg::ST_SQUARE;
            end
         end
         rbes_pkg::ST_ACCEL: begin
            state_in = rbes_pkg::ST_APPLY;
         end
         rbes_pkg::ST_APPLY: begin
            if (axis_ff == rbes_pkg::AXIS_LAST) begin
               state_in = rbes_pkg::ST_SQUARE;
               axis_in  = rbes_pkg::AXIS_FIRST;
            end else begin
               state_in = rbes_pkg::ST_ACCEL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         rbes_pkg::ST_SQUARE: begin
            if (axis_ff == rbes_pkg::AXIS_LAST) begin
               state_in = rbes_pkg::ST_DECIDE;
               axis_in  = rbes_pkg::AXIS_FIRST;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         rbes_pkg::ST_DECIDE: begin
            state_in = rbes_pkg::ST_DONE;
         end
         rbes_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = rbes_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbes_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_stall = 1'b1;
      case (state_ff)
         rbes_pkg::ST_IDLE: begin
            // nothing is taken while reset is high
            req_stall   = reset;
            cmd.capture = req_valid && !reset;
         end
         rbes_pkg::ST_START: begin
            cmd.start = 1'b1;
         end
         rbes_pkg::ST_ACCEL: begin
            cmd.accel = 1'b1;
         end
         rbes_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         rbes_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         rbes_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         rbes_pkg::ST_DONE: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd.axis = rbes_pkg::AXIS_FIRST;
         end
      endcase
   end

endmodule

[rtl/rbes_datapath.sv]
// datapath for the rigid body euler step block: registers, multipliers,
// body state and result register; depends on rbes_pkg, driven by rbes_ctrl
`timescale 1ns / 1ps

module rbes_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  rbes_pkg::req_payload_type req_payload,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [rbes_pkg::CSR_DATA_W-1:0] csr_data,
   input  rbes_pkg::dp_cmd_type    cmd,
   output rbes_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rbes_pkg::rsp_payload_type rsp_payload
);

   function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
      logic signed [15:0] r;
      if (v > 27'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -27'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // configuration
   logic [15:0] inv_mass_ff, inv_mass_in;
   logic [47:0] inv_inertia_ff, inv_inertia_in;
   logic [47:0] gravity_ff, gravity_in;
   logic [2:0]  mode_ff, mode_in;
   logic [15:0] speed_limit_ff, speed_limit_in;
   logic [23:0] time_limit_ff, time_limit_in;

   // body state
   logic signed [15:0] lin_vel_ff [3];
   logic signed [15:0] lin_vel_in [3];
   logic signed [15:0] ang_vel_ff [3];
   logic signed [15:0] ang_vel_in [3];
   logic               sleeping_ff, sleeping_in;
   logic [23:0]        timer_ff, timer_in;

   // work registers
   rbes_pkg::req_payload_type in_ff;
   logic signed [32:0] lin_acc_ff, ang_acc_ff;
   logic [31:0]        lin_sq_ff, ang_sq_ff, limit_sq_ff;

   // result register
   rbes_pkg::rsp_payload_type rsp_payload_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] in_vec [3];
   logic signed [15:0] in_torque [3];
   logic [15:0]        inv_arr [3];
   logic signed [15:0] grav_arr [3];

   logic signed [15:0] vec_sel, torque_sel, grav_sel, lin_sel, ang_sel;
   logic [15:0]        inv_sel;
   logic signed [32:0] lin_prod, ang_prod, grav_term;
   logic signed [49:0] lin_scaled, ang_scaled, lin_round, ang_round;
   logic signed [26:0] lin_sum, ang_sum;
   logic signed [31:0] lin_ext, ang_ext, lin_sq, ang_sq;
   logic [31:0]        limit_sq;
   logic [24:0]        timer_sum;
   logic [23:0]        timer_sat;
   logic               dynamic, push, vec_nonzero;

   assign in_vec[0]    = in_ff.vec_x;
   assign in_vec[1]    = in_ff.vec_y;
   assign in_vec[2]    = in_ff.vec_z;
   assign in_torque[0] = in_ff.torque_x;
   assign in_torque[1] = in_ff.torque_y;
   assign in_torque[2] = in_ff.torque_z;
   assign inv_arr[0]   = inv_inertia_ff[15:0];
   assign inv_arr[1]   = inv_inertia_ff[31:16];
   assign inv_arr[2]   = inv_inertia_ff[47:32];
   assign grav_arr[0]  = gravity_ff[15:0];
   assign grav_arr[1]  = gravity_ff[31:16];
   assign grav_arr[2]  = gravity_ff[47:32];

   assign vec_sel    = in_vec[cmd.axis];
   assign torque_sel = in_torque[cmd.axis];
   assign inv_sel    = inv_arr[cmd.axis];
   assign grav_sel   = grav_arr[cmd.axis];
   assign lin_sel    = lin_vel_ff[cmd.axis];
   assign ang_sel    = ang_vel_ff[cmd.axis];

   assign dynamic     = mode_ff[rbes_pkg::MODE_DYNAMIC];
   assign vec_nonzero = (in_ff.vec_x != 16'sd0) || (in_ff.vec_y != 16'sd0)
                        || (in_ff.vec_z != 16'sd0);
   assign push        = vec_nonzero || (in_ff.torque_x != 16'sd0)
                        || (in_ff.torque_y != 16'sd0) || (in_ff.torque_z != 16'sd0);

   // acceleration, Q16.16
   assign grav_term = mode_ff[rbes_pkg::MODE_GRAVITY]
                      ? $signed({{9{grav_sel[15]}}, grav_sel, 8'b0}) : 33'sd0;
   assign lin_prod  = $signed({{17{vec_sel[15]}}, vec_sel})
                      * $signed({17'b0, inv_mass_ff}) + grav_term;
   assign ang_prod  = $signed({{17{torque_sel[15]}}, torque_sel})
                      * $signed({17'b0, inv_sel});

   // velocity change, rounded to Q8.8
   assign lin_scaled = $signed({{17{lin_acc_ff[32]}}, lin_acc_ff})
                       * $signed({34'b0, in_ff.time_step});
   assign ang_scaled = $signed({{17{ang_acc_ff[32]}}, ang_acc_ff})
                       * $signed({34'b0, in_ff.time_step});
   assign lin_round  = lin_scaled + rbes_pkg::ROUND_HALF;
   assign ang_round  = ang_scaled + rbes_pkg::ROUND_HALF;
   assign lin_sum    = $signed({{11{lin_sel[15]}}, lin_sel})
                       + $signed({lin_round[49], lin_round[49:24]});
   assign ang_sum    = $signed({{11{ang_sel[15]}}, ang_sel})
                       + $signed({ang_round[49], ang_round[49:24]});

   // squared speeds
   assign lin_ext  = $signed({{16{lin_sel[15]}}, lin_sel});
   assign ang_ext  = $signed({{16{ang_sel[15]}}, ang_sel});
   assign lin_sq   = lin_ext * lin_ext;
   assign ang_sq   = ang_ext * ang_ext;
   assign limit_sq = {16'b0, speed_limit_ff} * {16'b0, speed_limit_ff};

   assign timer_sum = {1'b0, timer_ff} + {9'b0, in_ff.time_step};
   assign timer_sat = timer_sum[24] ? rbes_pkg::TIMER_MAX : timer_sum[23:0];

   assign status.is_step   = (in_ff.operation == rbes_pkg::OP_STEP);
   assign status.integrate = (in_ff.time_step != 16'd0) && dynamic
                             && (!sleeping_ff || push);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // next state of configuration and body
   always_comb begin
      inv_mass_in    = inv_mass_ff;
      inv_inertia_in = inv_inertia_ff;
      gravity_in     = gravity_ff;
      mode_in        = mode_ff;
      speed_limit_in = speed_limit_ff;
      time_limit_in  = time_limit_ff;
      lin_vel_in     = lin_vel_ff;
      ang_vel_in     = ang_vel_ff;
      sleeping_in    = sleeping_ff;
      timer_in       = timer_ff;

      if (cmd.start) begin
         case (in_ff.operation)
            rbes_pkg::OP_STEP: begin
               if (dynamic && push) begin
                  sleeping_in = 1'b0;
                  timer_in    = '0;
               end
            end
            rbes_pkg::OP_LOAD_LIN: begin
               lin_vel_in[0] = dynamic ? in_ff.vec_x : 16'sd0;
               lin_vel_in[1] = dynamic ? in_ff.vec_y : 16'sd0;
               lin_vel_in[2] = dynamic ? in_ff.vec_z : 16'sd0;
               if (dynamic && vec_nonzero) begin
                  sleeping_in = 1'b0;
                  timer_in    = '0;
               end
            end
            rbes_pkg::OP_LOAD_ANG: begin
               ang_vel_in[0] = dynamic ? in_ff.vec_x : 16'sd0;
               ang_vel_in[1] = dynamic ? in_ff.vec_y : 16'sd0;
               ang_vel_in[2] = dynamic ? in_ff.vec_z : 16'sd0;
               if (dynamic && vec_nonzero) begin
                  sleeping_in = 1'b0;
                  timer_in    = '0;
               end
            end
            default: begin
               sleeping_in = sleeping_ff;
            end
         endcase
      end

      if (cmd.apply) begin
         lin_vel_in[cmd.axis] = sat16(lin_sum);
         ang_vel_in[cmd.axis] = sat16(ang_sum);
      end

      if (cmd.decide) begin
         if (!mode_ff[rbes_pkg::MODE_SLEEP] || !dynamic) begin
            sleeping_in = 1'b0;
            timer_in    = '0;
         end else if (!sleeping_ff) begin
            if ((lin_sq_ff <= limit_sq_ff) && (ang_sq_ff <= limit_sq_ff)) begin
               if (timer_sat >= time_limit_ff) begin
                  sleeping_in = 1'b1;
                  timer_in    = time_limit_ff;
                  lin_vel_in  = '{default: 16'sd0};
                  ang_vel_in  = '{default: 16'sd0};
               end else begin
                  timer_in = timer_sat;
               end
            end else begin
               timer_in = '0;
            end
         end
      end

      if (csr_write_en) begin
         case (csr_index)
            rbes_pkg::CSR_INV_MASS:    inv_mass_in    = csr_data[15:0];
            rbes_pkg::CSR_INV_INERTIA: inv_inertia_in = csr_data[47:0];
            rbes_pkg::CSR_GRAVITY:     gravity_in     = csr_data[47:0];
            rbes_pkg::CSR_MODE: begin
               mode_in = csr_data[2:0];
               if (!csr_data[rbes_pkg::MODE_DYNAMIC]) begin
                  lin_vel_in = '{default: 16'sd0};
                  ang_vel_in = '{default: 16'sd0};
               end
               if (!csr_data[rbes_pkg::MODE_SLEEP]) begin
                  sleeping_in = 1'b0;
                  timer_in    = '0;
               end
            end
            rbes_pkg::CSR_SPEED_LIMIT: speed_limit_in = csr_data[15:0];
            rbes_pkg::CSR_TIME_LIMIT:  time_limit_in  = csr_data[23:0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff    <= rbes_pkg::INV_MASS_RESET;
         inv_inertia_ff <= rbes_pkg::INV_INERTIA_RESET;
         gravity_ff     <= rbes_pkg::GRAVITY_RESET;
         mode_ff        <= rbes_pkg::MODE_RESET;
         speed_limit_ff <= rbes_pkg::SPEED_LIMIT_RESET;
         time_limit_ff  <= rbes_pkg::TIME_LIMIT_RESET;
         lin_vel_ff     <= '{default: 16'sd0};
         ang_vel_ff     <= '{default: 16'sd0};
         sleeping_ff    <= 1'b0;
         timer_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         inv_mass_ff    <= inv_mass_in;
         inv_inertia_ff <= inv_inertia_in;
         gravity_ff     <= gravity_in;
         mode_ff        <= mode_in;
         speed_limit_ff <= speed_limit_in;
         time_limit_ff  <= time_limit_in;
         lin_vel_ff     <= lin_vel_in;
         ang_vel_ff     <= ang_vel_in;
         sleeping_ff    <= sleeping_in;
         timer_ff       <= timer_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_payload;
      end
      if (cmd.accel) begin
         lin_acc_ff <= lin_prod;
         ang_acc_ff <= ang_prod;
      end
      if (cmd.square) begin
         if (cmd.axis == rbes_pkg::AXIS_FIRST) begin
            lin_sq_ff   <= lin_sq;
            ang_sq_ff   <= ang_sq;
            limit_sq_ff <= limit_sq;
         end else begin
            lin_sq_ff <= lin_sq_ff + lin_sq;
            ang_sq_ff <= ang_sq_ff + ang_sq;
         end
      end
      if (cmd.finish) begin
         rsp_payload_ff.lin_vel_x <= lin_vel_ff[0];
         rsp_payload_ff.lin_vel_y <= lin_vel_ff[1];
         rsp_payload_ff.lin_vel_z <= lin_vel_ff[2];
         rsp_payload_ff.ang_vel_x <= ang_vel_ff[0];
         rsp_payload_ff.ang_vel_y <= ang_vel_ff[1];
         rsp_payload_ff.ang_vel_z <= ang_vel_ff[2];
         rsp_payload_ff.asleep    <= sleeping_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/rigid_body_euler_step_with_sleep_top.sv]
// rigid body velocity integrator with sleep, top level
// depends on rbes_pkg, rbes_ctrl and rbes_datapath
//
// usage:
//   req channel: one transaction per item (step, load linear or load angular
//   velocity); req_stall is high while an item is in work.
//   rsp channel: exactly one transaction per item, holding both velocity
//   vectors and the sleep flag after the item. rsp is held in an output
//   register, so the next item is taken while an earlier result is stalled.
//   csr port: single cycle writes, only while no item is in work.
// sequence (accept to rsp_valid): a start state; an integrating step then has
//   an acceleration and an apply state for each of the three axes; every step
//   then has a squaring state for each axis and a sleep decision state; a load
//   or an unused operation goes from start to the final state. The next item
//   is taken only once the final state is left, so items do not overlap.
// reset: synchronous; config returns to its defaults, velocities and quiet
//   timer clear, body is awake, rsp_valid drops, req_stall is held high.
// stall: a stalled result holds; the controller waits in its final state
//   until the output register frees before it takes another item.
`timescale 1ns / 1ps

module rigid_body_euler_step_with_sleep_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rbes_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rbes_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_en,
   input  logic [2:0]                csr_index,
   input  logic [rbes_pkg::CSR_DATA_W-1:0] csr_data
);

   rbes_pkg::dp_cmd_type    cmd;
   rbes_pkg::dp_status_type status;

   rbes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbes_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

[rtl/rbes_checker.sv]
// port level checks for the rigid body euler step block
// depends on rbes_pkg and the assertion macro header; bound to the top level
`timescale 1ns / 1ps
`include "rigid_body_euler_step_with_sleep_top_macros.svh"

module rbes_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input rbes_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rbes_pkg::rsp_payload_type rsp_payload
);

   logic req_fire;
   logic rsp_zero_vel;
   logic load_op;

   assign req_fire     = req_valid && !req_stall;
   assign load_op      = (req_payload.operation == rbes_pkg::OP_LOAD_LIN)
                         || (req_payload.operation == rbes_pkg::OP_LOAD_ANG);
   assign rsp_zero_vel = (rsp_payload.lin_vel_x == 16'sd0)
                         && (rsp_payload.lin_vel_y == 16'sd0)
                         && (rsp_payload.lin_vel_z == 16'sd0)
                         && (rsp_payload.ang_vel_x == 16'sd0)
                         && (rsp_payload.ang_vel_y == 16'sd0)
                         && (rsp_payload.ang_vel_z == 16'sd0);

   // stalled result holds
   `RBES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // a sleeping body reports zero velocities
   `RBES_ASSERT_SAME(a_sleep_zero, clock, reset, rsp_valid && rsp_payload.asleep, rsp_zero_vel)

   // one item in work at a time
   `RBES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, req_stall)

   // an accepted load does not raise rsp_valid at once when no result is pending
   `RBES_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_fire && load_op && !rsp_valid, !rsp_valid)

endmodule

bind rigid_body_euler_step_with_sleep_top rbes_checker u_rbes_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[test/tb_top.sv]
// self-checking testbench for rigid_body_euler_step_with_sleep_top
// depends on rbes_pkg and the top level rtl; a directed table and random phases are run
// against an in-bench velocity and sleep predictor
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic [2:0] CSR_SPARE_LO   = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI   = 3'd7;
   localparam int         PHASES         = 12;
   localparam int         ITEMS_PER_PHASE = 84;
   localparam int         DRAIN_CYCLES   = 16;
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct {
      bit                        is_csr;
      logic [2:0]                index;
      logic [47:0]               value;
      rbes_pkg::req_payload_type item;
      bit                        typed;
      rbes_pkg::rsp_payload_type want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   rbes_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rbes_pkg::rsp_payload_type rsp_payload;
   logic                      csr_write_en = 1'b0;
   logic [2:0]                csr_index = '0;
   logic [rbes_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // body state and register copies kept by the predictor
   logic [15:0]        inv_mass_r     = rbes_pkg::INV_MASS_RESET;
   logic [47:0]        inv_inertia_r  = rbes_pkg::INV_INERTIA_RESET;
   logic [47:0]        gravity_r      = rbes_pkg::GRAVITY_RESET;
   logic [2:0]         mode_r         = rbes_pkg::MODE_RESET;
   logic [15:0]        speed_limit_r  = rbes_pkg::SPEED_LIMIT_RESET;
   logic [23:0]        time_limit_r   = rbes_pkg::TIME_LIMIT_RESET;
   logic signed [15:0] lin_v [3]      = '{16'sd0, 16'sd0, 16'sd0};
   logic signed [15:0] ang_v [3]      = '{16'sd0, 16'sd0, 16'sd0};
   bit                 asleep_r       = 1'b0;
   logic [23:0]        quiet_r        = '0;

   rbes_pkg::rsp_payload_type pending_velocities [$];
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int idle_cycles     = 0;
   int mismatch_count  = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int asleep_results  = 0;
   int writes_done     = 0;

   rigid_body_euler_step_with_sleep_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_velocities();
      int i;
      for (i = 0; i < 3; i++) begin
         lin_v[i] = '0;
         ang_v[i] = '0;
      end
   endfunction

   function automatic void wake_body();
      asleep_r = 1'b0;
      quiet_r  = '0;
   endfunction

   function automatic logic signed [15:0] advance_axis(input logic signed [15:0] vel,
                                                       input longint accel,
                                                       input logic [15:0] dt);
      longint sum;
      sum = longint'(vel)
            + ((accel * longint'(dt) + longint'(rbes_pkg::ROUND_HALF)) >>> 24);
      if (sum > 32767) return 16'sh7FFF;
      if (sum < -32768) return 16'sh8000;
      return sum[15:0];
   endfunction

   function automatic longint speed_sq(input logic signed [15:0] x, y, z);
      return longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
   endfunction

   function automatic rbes_pkg::rsp_payload_type body_update(
      input rbes_pkg::req_payload_type item);
      logic signed [15:0]        drive_v [3];
      logic signed [15:0]        twist_v [3];
      logic [15:0]               dt;
      bit                        dyn;
      bit                        pushed;
      longint                    accel;
      longint                    lim;
      longint                    nt;
      int                        i;
      rbes_pkg::rsp_payload_type r;
      drive_v[0] = item.vec_x;
      drive_v[1] = item.vec_y;
      drive_v[2] = item.vec_z;
      twist_v[0] = item.torque_x;
      twist_v[1] = item.torque_y;
      twist_v[2] = item.torque_z;
      dt  = item.time_step;
      dyn = mode_r[rbes_pkg::MODE_DYNAMIC];
      case (item.operation)
         rbes_pkg::OP_STEP: begin
            pushed = (item.vec_x | item.vec_y | item.vec_z |
                      item.torque_x | item.torque_y | item.torque_z) != 0;
            if (dyn && pushed) wake_body();
            if (dt != 0 && dyn && !asleep_r) begin
               for (i = 0; i < 3; i++) begin
                  accel = longint'(drive_v[i]) * longint'(inv_mass_r);
                  if (mode_r[rbes_pkg::MODE_GRAVITY])
                     accel += longint'($signed(gravity_r[16*i +: 16])) * 256;
                  lin_v[i] = advance_axis(lin_v[i], accel, dt);
                  ang_v[i] = advance_axis(ang_v[i],
                     longint'(twist_v[i]) * longint'(inv_inertia_r[16*i +: 16]), dt);
               end
            end
            if (!mode_r[rbes_pkg::MODE_SLEEP] || !dyn) begin
               wake_body();
            end else if (!asleep_r) begin
               lim = longint'(speed_limit_r) * longint'(speed_limit_r);
               if (speed_sq(lin_v[0], lin_v[1], lin_v[2]) <= lim &&
                   speed_sq(ang_v[0], ang_v[1], ang_v[2]) <= lim) begin
                  nt = longint'(quiet_r) + longint'(dt);
                  quiet_r = (nt > longint'(rbes_pkg::TIMER_MAX)) ? rbes_pkg::TIMER_MAX
                                                                 : nt[23:0];
                  if (quiet_r >= time_limit_r) begin
                     asleep_r = 1'b1;
                     clear_velocities();
                     quiet_r = time_limit_r;
                  end
               end else begin
                  quiet_r = '0;
               end
            end
         end
         rbes_pkg::OP_LOAD_LIN, rbes_pkg::OP_LOAD_ANG: begin
            pushed = 1'b0;
            for (i = 0; i < 3; i++) begin
               if (item.operation == rbes_pkg::OP_LOAD_LIN)
                  lin_v[i] = dyn ? drive_v[i] : 16'sd0;
               else
                  ang_v[i] = dyn ? drive_v[i] : 16'sd0;
               if (dyn && drive_v[i] != 0) pushed = 1'b1;
            end
            if (pushed) wake_body();
         end
         default: ;
      endcase
      r.lin_vel_x = lin_v[0];
      r.lin_vel_y = lin_v[1];
      r.lin_vel_z = lin_v[2];
      r.ang_vel_x = ang_v[0];
      r.ang_vel_y = ang_v[1];
      r.ang_vel_z = ang_v[2];
      r.asleep    = asleep_r;
      return r;
   endfunction

   function automatic logic [15:0] gentle(input int span);
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic rbes_pkg::req_payload_type random_item();
      rbes_pkg::req_payload_type it;
      int                        pick;
      int                        span;
      pick = $urandom_range(0, 99);
      span = int'(speed_limit_r) / 2;
      it.operation = rbes_pkg::OP_STEP;
      it.vec_x     = 16'($urandom);
      it.vec_y     = 16'($urandom);
      it.vec_z     = 16'($urandom);
      it.torque_x  = 16'($urandom);
      it.torque_y  = 16'($urandom);
      it.torque_z  = 16'($urandom);
      case ($urandom_range(0, 7))
         0:       it.time_step = '0;
         1:       it.time_step = 16'hFFFF;
         2, 3:    it.time_step = 16'($urandom);
         default: it.time_step = 16'($urandom_range(1, 16'h0800));
      endcase
      if (pick < 5) begin
         it.operation = OP_UNUSED;
      end else if (pick < 20) begin
         it.operation = rbes_pkg::OP_STEP;
      end else if (pick < 35) begin
         // quiet step lets the sleep timer run
         it.vec_x = '0; it.vec_y = '0; it.vec_z = '0;
         it.torque_x = '0; it.torque_y = '0; it.torque_z = '0;
      end else if (pick < 65) begin
         it.vec_x    = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
         it.vec_y    = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
         it.vec_z    = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
         it.torque_x = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
         it.torque_y = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
         it.torque_z = ($urandom_range(0, 2) == 0) ? gentle(64) : 16'd0;
      end else begin
         it.operation = ($urandom_range(0, 1) == 0) ? rbes_pkg::OP_LOAD_LIN
                                                    : rbes_pkg::OP_LOAD_ANG;
         if (pick < 85) begin
            if ($urandom_range(0, 3) == 0) begin
               it.vec_x = '0; it.vec_y = '0; it.vec_z = '0;
            end else begin
               it.vec_x = gentle(span);
               it.vec_y = gentle(span);
               it.vec_z = gentle(span);
            end
         end
      end
      return it;
   endfunction

   function automatic directed_row_type item_row(input logic [1:0] op,
                                                 input logic [15:0] x, y, z, tx, ty, tz,
                                                 input logic [15:0] dt);
      directed_row_type row;
      row.is_csr = 1'b0;
      row.index  = '0;
      row.value  = '0;
      row.item   = {op, x, y, z, tx, ty, tz, dt};
      row.typed  = 1'b0;
      row.want   = '0;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input directed_row_type row,
                                                  input logic [15:0] lx, ly, lz, ax, ay, az,
                                                  input logic a);
      row.typed = 1'b1;
      row.want  = {lx, ly, lz, ax, ay, az, a};
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic [2:0] idx, input logic [47:0] value);
      directed_row_type row;
      row        = item_row(rbes_pkg::OP_STEP, '0, '0, '0, '0, '0, '0, '0);
      row.is_csr = 1'b1;
      row.index  = idx;
      row.value  = value;
      return row;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
         mismatch_count++;
      end
   endfunction

   task automatic send_item(input rbes_pkg::req_payload_type item, input bit typed,
                            input rbes_pkg::rsp_payload_type want);
      rbes_pkg::rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = body_update(item);
      pending_velocities.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic drain_and_hold();
      req_valid <= 1'b0;
      while (pending_velocities.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [47:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      case (idx)
         rbes_pkg::CSR_INV_MASS:    inv_mass_r    = value[15:0];
         rbes_pkg::CSR_INV_INERTIA: inv_inertia_r = value;
         rbes_pkg::CSR_GRAVITY:     gravity_r     = value;
         rbes_pkg::CSR_MODE: begin
            mode_r = value[2:0];
            if (!mode_r[rbes_pkg::MODE_DYNAMIC]) clear_velocities();
            if (!mode_r[rbes_pkg::MODE_SLEEP]) wake_body();
         end
         rbes_pkg::CSR_SPEED_LIMIT: speed_limit_r = value[15:0];
         rbes_pkg::CSR_TIME_LIMIT:  time_limit_r  = value[23:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
      writes_done++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin : check_results
      rbes_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_velocities.size() == 0) begin
            $display("%0t unexpected result transaction: expected none, actual %h",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = pending_velocities.pop_front();
            check_field("lin_vel_x", want.lin_vel_x, rsp_payload.lin_vel_x);
            check_field("lin_vel_y", want.lin_vel_y, rsp_payload.lin_vel_y);
            check_field("lin_vel_z", want.lin_vel_z, rsp_payload.lin_vel_z);
            check_field("ang_vel_x", want.ang_vel_x, rsp_payload.ang_vel_x);
            check_field("ang_vel_y", want.ang_vel_y, rsp_payload.ang_vel_y);
            check_field("ang_vel_z", want.ang_vel_z, rsp_payload.ang_vel_z);
            check_field("asleep", {15'd0, want.asleep}, {15'd0, rsp_payload.asleep});
            results_checked++;
            if (rsp_payload.asleep) asleep_results++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t no transaction for %0d cycles", $time, idle_cycles);
         $display("rigid_body_euler_step_with_sleep_top verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type directed_rows [$];
      directed_row_type row;
      logic [2:0]       mode_plan [PHASES];
      logic [15:0]      inv_cfg;
      logic [47:0]      inertia_cfg;
      logic [47:0]      gravity_cfg;
      logic [15:0]      speed_cfg;
      logic [23:0]      time_cfg;
      int               phase;
      int               axis;

      mode_plan = '{3'd7, 3'd7, 3'd5, 3'd3, 3'd1, 3'd6, 3'd7, 3'd0, 3'd4, 3'd2, 3'd7, 3'd5};

      // default registers: zero limits put a still body to sleep at once
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, 0, 1'b1));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_LOAD_LIN, 16'h7FFF, 16'h8000,
                                                 0, 0, 0, 0, 0),
                                        16'h7FFF, 16'h8000, 0, 0, 0, 0, 1'b0));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_LOAD_ANG, 16'h8000, 16'h7FFF,
                                                 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                 16'hFFFF),
                                        16'h7FFF, 16'h8000, 0, 16'h8000, 16'h7FFF, 16'h0001,
                                        1'b0));
      directed_rows.push_back(typed_row(item_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                        16'h7FFF, 16'h8000, 0, 16'h8000, 16'h7FFF, 16'h0001,
                                        1'b0));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 16'h7FFF, 16'h8000, 16'h0100,
                                       16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFF));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      directed_rows.push_back(item_row(rbes_pkg::OP_LOAD_LIN, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_LOAD_ANG, 0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, 0, 1'b0));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0,
                                                 16'h0001),
                                        0, 0, 0, 0, 0, 0, 1'b1));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0,
                                                 16'hFFFF),
                                        0, 0, 0, 0, 0, 0, 1'b1));
      // push wakes, zero step falls asleep again
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_STEP, 16'h0001, 0, 0, 0, 0, 0,
                                                 0),
                                        0, 0, 0, 0, 0, 0, 1'b1));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 16'h8000, 16'h8000, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 16'h0100, 16'hFF00,
                                       16'h0001, 16'h8000));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_GRAVITY, {16'h7FFF, 16'h8000, 16'hFF00}));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_SPEED_LIMIT, 48'h0100));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_TIME_LIMIT, 48'h000100));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_INV_MASS, 48'hFFFF));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_INV_INERTIA, 48'hFFFF_0000_0080));
      directed_rows.push_back(item_row(rbes_pkg::OP_LOAD_LIN, 16'h0040, 16'hFFC0, 16'h0020,
                                       0, 0, 0, 0));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 16'h0001, 0, 0, 0, 0, 16'h0003,
                                       16'h0080));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_MODE, 48'(3'b011)));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0040));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_MODE, 48'(3'b000)));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_LOAD_ANG, 16'h0005, 16'h0005,
                                                 16'h0005, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, 0, 1'b0));
      directed_rows.push_back(typed_row(item_row(rbes_pkg::OP_STEP, 16'h7FFF, 16'h7FFF,
                                                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                                 16'hFFFF),
                                        0, 0, 0, 0, 0, 0, 1'b0));
      directed_rows.push_back(csr_row(CSR_SPARE_LO, 48'hFFFF_FFFF_FFFF));
      directed_rows.push_back(csr_row(CSR_SPARE_HI, 48'hFFFF_FFFF_FFFF));
      directed_rows.push_back(csr_row(rbes_pkg::CSR_MODE, 48'(rbes_pkg::MODE_RESET)));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0080));
      directed_rows.push_back(item_row(rbes_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 16'h0080));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.is_csr) begin
            drain_and_hold();
            write_register(row.index, row.value);
         end else begin
            send_item(row.item, row.typed, row.want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_and_hold();
         case (phase)
            0: begin
               inv_cfg = '0; inertia_cfg = '0; gravity_cfg = '0;
               speed_cfg = '0; time_cfg = '0;
            end
            1: begin
               inv_cfg = '1; inertia_cfg = '1; gravity_cfg = '1;
               speed_cfg = '1; time_cfg = '1;
            end
            default: begin
               inv_cfg = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16'h0400));
               for (axis = 0; axis < 3; axis++) begin
                  inertia_cfg[16*axis +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 16'h0400));
                  gravity_cfg[16*axis +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : gentle(16'h0100);
               end
               speed_cfg = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 16'h0800));
               time_cfg  = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 24'h020000));
            end
         endcase
         write_register(rbes_pkg::CSR_INV_MASS, 48'(inv_cfg));
         write_register(rbes_pkg::CSR_INV_INERTIA, inertia_cfg);
         write_register(rbes_pkg::CSR_GRAVITY, gravity_cfg);
         write_register(rbes_pkg::CSR_SPEED_LIMIT, 48'(speed_cfg));
         write_register(rbes_pkg::CSR_TIME_LIMIT, 48'(time_cfg));
         write_register(rbes_pkg::CSR_MODE, 48'(mode_plan[phase]));
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 77; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 77; end
            default: begin send_idle_pct = 11; stall_pct <= 11; end
         endcase
         repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
      end

      drain_and_hold();
      $display("covered %0d items in %0d register settings, %0d results compared",
               items_sent, PHASES + 1, results_checked);
      $display("%0d results reported a sleeping body, %0d register writes, %0d mismatches",
               asleep_results, writes_done, mismatch_count);
      if (mismatch_count == 0)
         $display("rigid_body_euler_step_with_sleep_top verification clean");
      else
         $display("rigid_body_euler_step_with_sleep_top verification failed");
      $finish;
   end

endmodule
